/* rtl/core/byte_stuffed_frame_receiver_core_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the byte-stuffed frame receiver
// ----------------------------------------------------------------------------
`ifndef BYTE_STUFFED_FRAME_RECEIVER_CORE_MACROS_SVH
`define BYTE_STUFFED_FRAME_RECEIVER_CORE_MACROS_SVH

// Clocked assertion, masked while reset is asserted
`define BSFR_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Clocked assertion that also holds during reset
`define BSFR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* rtl/core/bsfr_pkg.sv */
// ----------------------------------------------------------------------------
// bsfr_pkg
// Types and constants shared by the byte-stuffed frame receiver files.
// ----------------------------------------------------------------------------
package bsfr_pkg;

  // Frame buffer size in payload bytes
  localparam int unsigned MAX_FRAME_BYTES = 256;
  localparam int unsigned CNT_W = $clog2(MAX_FRAME_BYTES + 1);

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned INDEX_W = 8;
  localparam int unsigned LEN_W   = 9;
  localparam int unsigned KIND_W  = 3;
  localparam int unsigned CFG_IDX_W = 2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_START  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_END    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ESCAPE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MASK   = 2'd3;

  // Register reset values
  localparam logic [BYTE_W-1:0] START_RST  = 8'd2;
  localparam logic [BYTE_W-1:0] END_RST    = 8'd3;
  localparam logic [BYTE_W-1:0] ESCAPE_RST = 8'd27;
  localparam logic [BYTE_W-1:0] MASK_RST   = 8'd32;

  typedef enum logic [KIND_W-1:0] {
    KIND_NONE    = 3'd0,
    KIND_DATA    = 3'd1,
    KIND_DONE    = 3'd2,
    KIND_NOSPACE = 3'd3,
    KIND_LOST    = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_FRAME = 2'd1,
    PH_ESC   = 2'd2
  } phase_e;

  // Control byte set handed from the register block to the core
  typedef struct packed {
    logic [BYTE_W-1:0] start_byte;
    logic [BYTE_W-1:0] end_byte;
    logic [BYTE_W-1:0] escape_byte;
    logic [BYTE_W-1:0] stuff_mask;
  } cfg_t;

  // One result item
  typedef struct packed {
    kind_e              kind;
    logic [BYTE_W-1:0]  data_byte;
    logic [INDEX_W-1:0] byte_index;
    logic [LEN_W-1:0]   frame_length;
    logic               frame_overflowed;
    logic               aborted_previous;
  } result_t;

endpackage

/* rtl/core/bsfr_if.sv */
// ----------------------------------------------------------------------------
// bsfr_rx_if / bsfr_res_if
// Valid/ready channels for received bytes and for receiver results.
// ----------------------------------------------------------------------------
interface bsfr_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       space_free;

  modport source (output valid, output rx_byte, output space_free, input ready);
  modport sink   (input valid, input rx_byte, input space_free, output ready);
endinterface

interface bsfr_res_if;
  logic       valid;
  logic       ready;
  logic [2:0] kind;
  logic [7:0] data_byte;
  logic [7:0] byte_index;
  logic [8:0] frame_length;
  logic       frame_overflowed;
  logic       aborted_previous;

  modport source (output valid, output kind, output data_byte, output byte_index,
                  output frame_length, output frame_overflowed,
                  output aborted_previous, input ready);
  modport sink   (input valid, input kind, input data_byte, input byte_index,
                  input frame_length, input frame_overflowed,
                  input aborted_previous, output ready);
endinterface

/* rtl/core/byte_stuffed_frame_receiver_core.sv */
// ----------------------------------------------------------------------------
// byte_stuffed_frame_receiver_core
// Hunts for a start byte, removes escape stuffing and reports frame events.
// ----------------------------------------------------------------------------
// Usage:
//   rx_i carries one raw byte per request, with space_free telling whether a
//   frame buffer is free should that byte be a start byte.
//   res_o carries exactly one result per accepted byte: a data byte with its
//   index, a frame-complete length, a dropped frame, a lost byte, or nothing.
//   The control bytes are set through cfg_we_i / cfg_idx_i / cfg_wdata_i
//   while the channels are quiet.
// Timing and throughput:
//   The result of a byte is registered onto res_o in the cycle after it is
//   accepted. One byte is accepted every cycle unless res_o stalls; the single
//   output register is refilled in the same cycle it is drained, so rx_i.ready
//   follows res_o.ready combinationally while a result is held.
// Stall:
//   While res_o holds an untaken result, rx_i.ready is low; nothing is lost.
// Reset:
//   Control bytes return to start 2, end 3, escape 27, mask 32; the receiver
//   goes idle with an empty count and the output register is emptied.
// ----------------------------------------------------------------------------
module byte_stuffed_frame_receiver_core import bsfr_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [BYTE_W-1:0]    cfg_wdata_i,
  bsfr_rx_if.sink              rx_i,
  bsfr_res_if.source           res_o
);

  cfg_t cfg;

  bsfr_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  phase_e            phase_q, phase_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              ovf_q, ovf_d;
  logic              out_valid_q;
  result_t           res_q, res_d;
  logic              accept;
  logic              store_en;
  logic [BYTE_W-1:0] store_val;

  assign rx_i.ready = !out_valid_q || res_o.ready;
  assign accept     = rx_i.valid && rx_i.ready;

  // Next state and result for the byte on rx_i
  always_comb begin
    res_d     = '0;
    phase_d   = phase_q;
    cnt_d     = cnt_q;
    ovf_d     = ovf_q;
    store_en  = 1'b0;
    store_val = rx_i.rx_byte;

    if (rx_i.rx_byte == cfg.start_byte) begin
      // start always restarts, in any phase
      res_d.aborted_previous = (phase_q == PH_FRAME) || (phase_q == PH_ESC);
      cnt_d = '0;
      ovf_d = 1'b0;
      if (rx_i.space_free) begin
        phase_d = PH_FRAME;
      end else begin
        phase_d    = PH_IDLE;
        res_d.kind = KIND_NOSPACE;
      end
    end else begin
      case (phase_q)
        PH_FRAME: begin
          if (rx_i.rx_byte == cfg.escape_byte) begin
            phase_d = PH_ESC;
          end else if (rx_i.rx_byte == cfg.end_byte) begin
            res_d.kind             = KIND_DONE;
            res_d.frame_length     = LEN_W'(cnt_q);
            res_d.frame_overflowed = ovf_q;
            phase_d = PH_IDLE;
            cnt_d   = '0;
            ovf_d   = 1'b0;
          end else begin
            store_en = 1'b1;
          end
        end
        PH_ESC: begin
          store_en  = 1'b1;
          store_val = rx_i.rx_byte ^ cfg.stuff_mask;
          phase_d   = PH_FRAME;
        end
        default: begin
          // idle, and the unused phase code, ignore non-start bytes
          phase_d = PH_IDLE;
        end
      endcase
    end

    // Payload store with overflow check
    if (store_en) begin
      if (cnt_q < CNT_W'(MAX_FRAME_BYTES)) begin
        res_d.kind       = KIND_DATA;
        res_d.data_byte  = store_val;
        res_d.byte_index = INDEX_W'(cnt_q);
        cnt_d            = cnt_q + 1'b1;
      end else begin
        res_d.kind = KIND_LOST;
        ovf_d      = 1'b1;
      end
    end
  end

  // Receiver state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      cnt_q   <= '0;
      ovf_q   <= 1'b0;
    end else if (accept) begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      ovf_q   <= ovf_d;
    end
  end

  // Output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (rx_i.ready) begin
      out_valid_q <= rx_i.valid;
    end
  end

  // Output register payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

  assign res_o.valid            = out_valid_q;
  assign res_o.kind             = res_q.kind;
  assign res_o.data_byte        = res_q.data_byte;
  assign res_o.byte_index       = res_q.byte_index;
  assign res_o.frame_length     = res_q.frame_length;
  assign res_o.frame_overflowed = res_q.frame_overflowed;
  assign res_o.aborted_previous = res_q.aborted_previous;

endmodule

/* rtl/core/bsfr_cfg_regs.sv */
// ----------------------------------------------------------------------------
// bsfr_cfg_regs
// Control byte registers: start, end, escape and stuff mask.
// ----------------------------------------------------------------------------
module bsfr_cfg_regs import bsfr_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [BYTE_W-1:0]    cfg_wdata_i,
  output cfg_t                 cfg_o
);

  cfg_t cfg_q, cfg_d;

  // Write decode
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_START:  cfg_d.start_byte  = cfg_wdata_i;
        REG_END:    cfg_d.end_byte    = cfg_wdata_i;
        REG_ESCAPE: cfg_d.escape_byte = cfg_wdata_i;
        REG_MASK:   cfg_d.stuff_mask  = cfg_wdata_i;
        default:    cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_byte  <= START_RST;
      cfg_q.end_byte    <= END_RST;
      cfg_q.escape_byte <= ESCAPE_RST;
      cfg_q.stuff_mask  <= MASK_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* rtl/core/bsfr_checker.sv */
// ----------------------------------------------------------------------------
// bsfr_checker
// Port-level checks on the frame receiver, bound to the top level.
// ----------------------------------------------------------------------------
`include "byte_stuffed_frame_receiver_core_macros.svh"

module bsfr_checker import bsfr_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_i,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input logic [KIND_W-1:0]  kind_i,
  input logic [BYTE_W-1:0]  data_byte_i,
  input logic [INDEX_W-1:0] byte_index_i,
  input logic [LEN_W-1:0]   frame_length_i,
  input logic               frame_overflowed_i
);

  // A held result stays valid, with its kind and data byte unchanged, until taken
  `BSFR_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i |=> out_valid_i && $stable(kind_i) && $stable(data_byte_i), "result changed while stalled")

  // An empty output register always takes a new byte
  `BSFR_ASSERT_ALWAYS(a_ready_when_empty, clk_i, !out_valid_i |-> in_ready_i, "input stalled with empty output register")

  // Every accepted byte produces a result in the next cycle
  `BSFR_ASSERT(a_one_result, clk_i, rst_ni, in_valid_i && in_ready_i |=> out_valid_i, "accepted byte gave no result")

  // Data fields are zero unless a data byte is reported
  `BSFR_ASSERT(a_data_zero, clk_i, rst_ni, out_valid_i && kind_i != KIND_DATA |-> data_byte_i == '0 && byte_index_i == '0, "data fields set on non-data result")

  // Length fields are zero unless a frame completes
  `BSFR_ASSERT(a_len_zero, clk_i, rst_ni, out_valid_i && kind_i != KIND_DONE |-> frame_length_i == '0 && !frame_overflowed_i, "length set on non-complete result")

endmodule

bind byte_stuffed_frame_receiver_core bsfr_checker u_bsfr_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .in_valid_i         (rx_i.valid),
  .in_ready_i         (rx_i.ready),
  .out_valid_i        (res_o.valid),
  .out_ready_i        (res_o.ready),
  .kind_i             (res_o.kind),
  .data_byte_i        (res_o.data_byte),
  .byte_index_i       (res_o.byte_index),
  .frame_length_i     (res_o.frame_length),
  .frame_overflowed_i (res_o.frame_overflowed)
);
